@@ rtl/spfc_pkg.sv @@
package spfc_pkg;

    localparam int PixelWidth = 32;
    localparam int ApbDataWidth = 32;
    localparam int ApbAddrWidth = 3;
    localparam int ModeWidth = 3;

    // Register index decoded from paddr[ApbAddrWidth-1:2].
    localparam logic REG_FORMAT_MODE = 1'b0;

    typedef enum logic [ModeWidth-1:0] {
        MODE_ARGB8888_SWAP   = 3'd0,
        MODE_ABGR8888_PASS   = 3'd1,
        MODE_RGB10A2_FLIP    = 3'd2,
        MODE_RGB10A2_NOFLIP  = 3'd3,
        MODE_BGR888          = 3'd4,
        MODE_RGB888          = 3'd5,
        MODE_UNSUPPORTED     = 3'd6
    } mode_t;

    typedef struct packed {
        logic [PixelWidth-1:0] pixel_out;
        logic                  supported;
    } result_t;

endpackage

@@ rtl/spfc_in_if.sv @@
interface spfc_in_if;

    logic                              valid;
    logic                              ready;
    logic [spfc_pkg::PixelWidth-1:0]   pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);

endinterface

@@ rtl/spfc_out_if.sv @@
interface spfc_out_if;

    logic                              valid;
    logic                              ready;
    logic [spfc_pkg::PixelWidth-1:0]   pixel_out;
    logic                              supported;

    modport source (output valid, output pixel_out, output supported, input ready);
    modport sink (input valid, input pixel_out, input supported, output ready);

endinterface

@@ rtl/spfc_cfg_regs.sv @@
module spfc_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spfc_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [spfc_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [spfc_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                pready,
    output spfc_pkg::mode_t                     format_mode
);

    logic [spfc_pkg::ModeWidth-1:0] mode_reg;
    logic [spfc_pkg::ModeWidth-1:0] mode_next;
    logic                           reg_sel;

    assign pready = 1'b1;
    assign reg_sel = (paddr[spfc_pkg::ApbAddrWidth-1:2] == spfc_pkg::REG_FORMAT_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            mode_next = pwdata[spfc_pkg::ModeWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= spfc_pkg::MODE_ARGB8888_SWAP;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = {{(spfc_pkg::ApbDataWidth - spfc_pkg::ModeWidth){1'b0}}, mode_reg};
        end
    end

    assign format_mode = spfc_pkg::mode_t'(mode_reg);

endmodule

@@ rtl/spfc_convert.sv @@
module spfc_convert
(
    input  logic [spfc_pkg::PixelWidth-1:0] pixel,
    input  spfc_pkg::mode_t                 format_mode,
    output spfc_pkg::result_t               result
);

    // Computes (170*v + 341) / 682, which is round(v*255/1023). The quotient
    // is estimated by multiplying with 384/2^18, which is never too large and
    // at most one too small, and then corrected with one compare.
    function automatic logic [7:0] ten_to_eight(input logic [9:0] v);
        logic [17:0] num;
        logic [26:0] prod;
        logic [8:0]  q_est;
        logic [17:0] rem;
        logic [8:0]  q;
        num = 18'(v) * 18'd170 + 18'd341;
        prod = 27'(num) * 27'd384;
        q_est = prod[26:18];
        rem = num - 18'(q_est) * 18'd682;
        q = (rem >= 18'd682) ? q_est + 9'd1 : q_est;
        return q[7:0];
    endfunction

    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] alpha;

    assign c0 = ten_to_eight(pixel[9:0]);
    assign c1 = ten_to_eight(pixel[19:10]);
    assign c2 = ten_to_eight(pixel[29:20]);
    // Multiplying a two-bit value by 85 replicates it four times.
    assign alpha = {4{pixel[31:30]}};

    always_comb
    begin
        result.pixel_out = pixel;
        result.supported = 1'b1;
        case (format_mode)
            spfc_pkg::MODE_ARGB8888_SWAP:
            begin
                result.pixel_out = {pixel[31:24], pixel[7:0], pixel[15:8], pixel[23:16]};
            end
            spfc_pkg::MODE_ABGR8888_PASS:
            begin
                result.pixel_out = pixel;
            end
            spfc_pkg::MODE_RGB10A2_FLIP:
            begin
                result.pixel_out = {alpha, c0, c1, c2};
            end
            spfc_pkg::MODE_RGB10A2_NOFLIP:
            begin
                result.pixel_out = {alpha, c2, c1, c0};
            end
            spfc_pkg::MODE_BGR888, spfc_pkg::MODE_RGB888:
            begin
                result.pixel_out = {8'hFF, pixel[23:0]};
            end
            default:
            begin
                result.pixel_out = pixel;
                result.supported = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/screen_pixel_format_converter.sv @@
// Channel   Modport  Payload             Transaction
// in_chan   sink     pixel_in            valid && ready
// out_chan  source   pixel_out, supported valid && ready
// apb       slave    format_mode         psel && penable && pwrite && pready
//
// A pixel is held in the input register after its transaction and its result is then
// loaded into the result register when that register is empty or being taken.
// One pixel is accepted per cycle while the output is taken every cycle.
// Latency is set by the input register and the result register.
// Reset clears the valid bits and sets the mode to ARGB8888 swap.
// A stalled output holds its result and stalls the input stage behind it once that stage holds a pixel.
module screen_pixel_format_converter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spfc_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [spfc_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [spfc_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                pready,
    spfc_in_if.sink                             in_chan,
    spfc_out_if.source                          out_chan
);

    spfc_pkg::mode_t                  format_mode;
    spfc_pkg::result_t                conv_result;

    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [spfc_pkg::PixelWidth-1:0]  in_pixel_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    spfc_pkg::result_t                out_result_reg;
    logic                             out_load;
    logic                             in_load;

    spfc_cfg_regs u_cfg_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .format_mode (format_mode)
    );

    spfc_convert u_convert
    (
        .pixel       (in_pixel_reg),
        .format_mode (format_mode),
        .result      (conv_result)
    );

    assign out_load = !out_valid_reg || out_chan.ready;
    assign in_load = !in_valid_reg || out_load;
    assign in_chan.ready = in_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_load)
        begin
            in_valid_next = in_chan.valid;
        end
        if (out_load)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_chan.valid)
        begin
            in_pixel_reg <= in_chan.pixel_in;
        end
        if (out_load && in_valid_reg)
        begin
            out_result_reg <= conv_result;
        end
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.pixel_out = out_result_reg.pixel_out;
    assign out_chan.supported = out_result_reg.supported;

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_chan.valid && in_chan.ready |=> in_valid_reg)
        else $error("accepted pixel did not reach the input register");

    a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg && !out_valid_reg |-> in_chan.ready)
        else $error("empty pipeline refused a transaction");

    a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_chan.ready |=> in_valid_reg)
        else $error("input register lost a pixel during a stall");

endmodule

@@ tb/sv/tb_screen_pixel_format_converter.sv @@
module tb_screen_pixel_format_converter;

    localparam logic [spfc_pkg::ApbAddrWidth-1:0] ADDR_FORMAT_MODE =
        {spfc_pkg::REG_FORMAT_MODE, 2'b00};
    localparam logic [spfc_pkg::ApbAddrWidth-1:0] ADDR_UNUSED =
        {!spfc_pkg::REG_FORMAT_MODE, 2'b00};
    localparam int RandomPhases = 8;
    localparam int PhaseItems = 180;
    localparam int SettleCycles = 4;

    class pixel_scoreboard;
        spfc_pkg::result_t expected_q[$];
        int failures;
        int shown;

        function new();
            failures = 0;
            shown = 0;
        endfunction

        function logic [7:0] scale_channel(logic [9:0] v);
            logic [31:0] t;
            t = (32'd170 * v + 32'd341) / 32'd682;
            return t[7:0];
        endfunction

        function spfc_pkg::result_t convert_pixel(logic [spfc_pkg::PixelWidth-1:0] p,
                                                  logic [spfc_pkg::ModeWidth-1:0] mode);
            spfc_pkg::result_t r;
            logic [7:0] c0;
            logic [7:0] c1;
            logic [7:0] c2;
            logic [7:0] alpha;
            c0 = scale_channel(p[9:0]);
            c1 = scale_channel(p[19:10]);
            c2 = scale_channel(p[29:20]);
            alpha = {6'd0, p[31:30]} * 8'd85;
            r.supported = 1'b1;
            case (mode)
                spfc_pkg::MODE_ARGB8888_SWAP: r.pixel_out = {p[31:24], p[7:0], p[15:8], p[23:16]};
                spfc_pkg::MODE_ABGR8888_PASS: r.pixel_out = p;
                spfc_pkg::MODE_RGB10A2_FLIP: r.pixel_out = {alpha, c0, c1, c2};
                spfc_pkg::MODE_RGB10A2_NOFLIP: r.pixel_out = {alpha, c2, c1, c0};
                spfc_pkg::MODE_BGR888, spfc_pkg::MODE_RGB888: r.pixel_out = {8'hFF, p[23:0]};
                default:
                begin
                    r.pixel_out = p;
                    r.supported = 1'b0;
                end
            endcase
            return r;
        endfunction

        function void note_pixel(logic [spfc_pkg::PixelWidth-1:0] p,
                                 logic [spfc_pkg::ModeWidth-1:0] mode);
            expected_q.push_back(convert_pixel(p, mode));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(logic [spfc_pkg::PixelWidth-1:0] pixel, logic sup);
            spfc_pkg::result_t exp_r;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected transaction: pixel_out=%h supported=%b", pixel, sup);
                end
                return;
            end
            exp_r = expected_q.pop_front();
            if (pixel !== exp_r.pixel_out || sup !== exp_r.supported)
            begin
                failures++;
                if (shown < 10)
                begin
                    shown++;
                    $display("mismatch: pixel_out expected %h got %h, supported expected %b got %b",
                             exp_r.pixel_out, pixel, exp_r.supported, sup);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [spfc_pkg::ApbAddrWidth-1:0] paddr;
    logic [spfc_pkg::ApbDataWidth-1:0] pwdata;
    logic [spfc_pkg::ApbDataWidth-1:0] prdata;
    logic pready;

    spfc_in_if in_chan();
    spfc_out_if out_chan();

    screen_pixel_format_converter dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_chan(in_chan),
        .out_chan(out_chan)
    );

    pixel_scoreboard sb = new();
    logic [spfc_pkg::ModeWidth-1:0] cur_mode;
    bit source_idle_en;
    bit sink_stall_en;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function int pick_gap(bit enabled, int min_len);
        int r;
        if (!enabled)
        begin
            return min_len;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return min_len;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function logic [9:0] edge_channel();
        case ($urandom_range(0, 5))
            0: return 10'h000;
            1: return 10'h001;
            2: return 10'h3FF;
            3: return 10'h3FE;
            4: return 10'h1FF;
            default: return 10'h200;
        endcase
    endfunction

    function logic [spfc_pkg::PixelWidth-1:0] random_pixel();
        if ($urandom_range(0, 7) == 0)
        begin
            return {2'($urandom_range(0, 3)), edge_channel(), edge_channel(), edge_channel()};
        end
        return $urandom();
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        begin
            sb.check_result(out_chan.pixel_out, out_chan.supported);
        end
    end

    initial
    begin
        int len;
        out_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_stall_en && $urandom_range(0, 3) == 0)
            begin
                len = pick_gap(1'b1, 1);
                out_chan.ready <= 1'b0;
                repeat (len) @(negedge clk);
            end
            out_chan.ready <= 1'b1;
        end
    end

    initial
    begin
        #10000000;
        $display("screen_pixel_format_converter test failed");
        $finish;
    end

    task automatic apb_write(input logic [spfc_pkg::ApbAddrWidth-1:0] addr,
                             input logic [spfc_pkg::ApbDataWidth-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == ADDR_FORMAT_MODE)
        begin
            cur_mode = data[spfc_pkg::ModeWidth-1:0];
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_mode(input logic [spfc_pkg::ModeWidth-1:0] mode);
        logic [spfc_pkg::ApbDataWidth-1:0] data;
        data = {$urandom_range(0, 1) ? $urandom() : 32'd0};
        data[spfc_pkg::ModeWidth-1:0] = mode;
        apb_write(ADDR_FORMAT_MODE, data);
    endtask

    task automatic send_pixel(input logic [spfc_pkg::PixelWidth-1:0] p);
        int gap;
        in_chan.valid <= 1'b1;
        in_chan.pixel_in <= p;
        do @(posedge clk); while (in_chan.ready !== 1'b1);
        sb.note_pixel(p, cur_mode);
        gap = pick_gap(source_idle_en, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            in_chan.pixel_in <= $urandom();
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_results();
        in_chan.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic drain();
        wait_results();
        repeat (SettleCycles) @(negedge clk);
    endtask

    initial
    begin
        logic [spfc_pkg::PixelWidth-1:0] fixed_pixels [3];
        fixed_pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5C3_0F69};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_chan.valid = 1'b0;
        in_chan.pixel_in = '0;
        cur_mode = spfc_pkg::MODE_ARGB8888_SWAP;
        source_idle_en = 1'b1;
        sink_stall_en = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_pixel(32'h1122_3344);
        drain();
        for (int m = 0; m < 8; m++)
        begin
            set_mode(spfc_pkg::ModeWidth'(m));
            if (m == 3)
            begin
                @(negedge clk);
                apb_write(ADDR_UNUSED, $urandom());
            end
            foreach (fixed_pixels[i])
            begin
                send_pixel(fixed_pixels[i]);
            end
            drain();
        end

        for (int ph = 0; ph < RandomPhases; ph++)
        begin
            if (ph == 0)
            begin
                set_mode(spfc_pkg::MODE_ARGB8888_SWAP);
            end
            else if (ph == RandomPhases - 1)
            begin
                set_mode(3'd7);
            end
            else
            begin
                set_mode(spfc_pkg::ModeWidth'($urandom_range(0, 7)));
            end
            source_idle_en = (ph != 3);
            sink_stall_en = (ph != 3);
            for (int i = 0; i < PhaseItems; i++)
            begin
                send_pixel(random_pixel());
                if ((ph == 2 && i == 50) || $urandom_range(0, 99) == 0)
                begin
                    wait_results();
                end
            end
            drain();
        end

        if (sb.failures == 0)
        begin
            $display("screen_pixel_format_converter test passed");
        end
        else
        begin
            $display("screen_pixel_format_converter test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/spfc_pkg.sv
rtl/spfc_in_if.sv
rtl/spfc_out_if.sv
rtl/spfc_cfg_regs.sv
rtl/spfc_convert.sv
rtl/screen_pixel_format_converter.sv
tb/sv/tb_screen_pixel_format_converter.sv
